// File: hdl/ttbi_pkg.sv
package ttbi_pkg;

   // default array sizes
   localparam int MAX_ROWS_DEFAULT    = 8;
   localparam int MAX_COLUMNS_DEFAULT = 8;

   // field widths
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 4;
   localparam int OP_W      = 2;
   localparam int SLOT_W    = 3;
   localparam int CSR_IDX_W = 1;
   localparam int WIDE_W    = 64;
   localparam int DELTA_W   = 33;
   localparam int PROD_W    = 96;

   // operation codes
   localparam logic [OP_W-1:0] OP_ROW_BP    = 2'd0;
   localparam logic [OP_W-1:0] OP_COLUMN_BP = 2'd1;
   localparam logic [OP_W-1:0] OP_ENTRY     = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 1'b1;

   // clamp bound for intermediate values, 2^61
   localparam logic signed [WIDE_W-1:0] WIDE_LIMIT = 64'sh2000_0000_0000_0000;

   // one lerp: a + (b-a)*e/d
   typedef struct packed {
      logic signed [WIDE_W-1:0]  a;
      logic signed [WIDE_W-1:0]  b;
      logic signed [DELTA_W-1:0] e;
      logic signed [DELTA_W-1:0] d;
   } lerp_req_type;

   typedef struct packed {
      logic signed [WIDE_W-1:0] value;
      logic                     clamped;
   } lerp_rsp_type;

endpackage

// File: hdl/ttbi_ram.sv
module ttbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: hdl/ttbi_lerp.sv
module ttbi_lerp (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  ttbi_pkg::lerp_req_type req,
   output logic                  done,
   output ttbi_pkg::lerp_rsp_type rsp
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_MUL  = 2'd1;
   localparam logic [1:0] L_DIV  = 2'd2;
   localparam logic [1:0] L_FIN  = 2'd3;

   localparam int PW = ttbi_pkg::PROD_W;
   localparam int DW = ttbi_pkg::DELTA_W;
   localparam int WW = ttbi_pkg::WIDE_W;

   logic [1:0]               state_ff, state_in;
   logic [6:0]               step_ff, step_in;
   logic signed [WW-1:0]     a_ff, a_in;
   logic                     neg_ff, neg_in;
   logic [DW-1:0]            dmag_ff, dmag_in;
   logic [DW-1:0]            emag_ff, emag_in;
   logic [WW-2:0]            dfmag_ff, dfmag_in;
   logic [PW-1:0]            acc_ff, acc_in;
   logic [DW-1:0]            rem_ff, rem_in;
   logic                     done_ff, done_in;
   ttbi_pkg::lerp_rsp_type   rsp_ff, rsp_in;

   logic signed [WW-1:0]     diff;
   logic signed [WW-1:0]     diff_abs;
   logic signed [DW-1:0]     e_abs;
   logic signed [DW-1:0]     d_abs;
   logic [DW:0]              rem_sh;
   logic                     q_ge;
   logic                     q_over;
   logic signed [WW-1:0]     q_clamped;
   logic signed [WW-1:0]     res;

   // operand magnitudes and sign
   assign diff     = req.b - req.a;
   assign diff_abs = diff[WW-1] ? -diff : diff;
   assign e_abs    = req.e[DW-1] ? -req.e : req.e;
   assign d_abs    = req.d[DW-1] ? -req.d : req.d;

   // restoring division step
   assign rem_sh = {rem_ff, acc_ff[PW-1]};
   assign q_ge   = rem_sh >= {1'b0, dmag_ff};

   // quotient clamp and final add
   assign q_over    = (|acc_ff[PW-1:62]) || (acc_ff[61] && (|acc_ff[60:0]));
   assign q_clamped = q_over ? ttbi_pkg::WIDE_LIMIT : $signed({2'b00, acc_ff[61:0]});
   assign res       = neg_ff ? a_ff - q_clamped : a_ff + q_clamped;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      a_in     = a_ff;
      neg_in   = neg_ff;
      dmag_in  = dmag_ff;
      emag_in  = emag_ff;
      dfmag_in = dfmag_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      rsp_in   = rsp_ff;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               a_in     = req.a;
               dfmag_in = diff_abs[WW-2:0];
               emag_in  = e_abs;
               dmag_in  = d_abs;
               acc_in   = '0;
               rem_in   = '0;
               step_in  = '0;
               // zero-width segment: quotient stays zero
               if (req.d == '0) begin
                  neg_in   = 1'b0;
                  state_in = L_FIN;
               end else begin
                  neg_in   = diff[WW-1] ^ req.e[DW-1] ^ req.d[DW-1];
                  state_in = L_MUL;
               end
            end
         end
         L_MUL: begin
            // shift-add over the bits of |e|, msb first
            acc_in  = {acc_ff[PW-2:0], 1'b0} +
                      (emag_ff[DW-1] ? {{(PW-WW+1){1'b0}}, dfmag_ff} : '0);
            emag_in = {emag_ff[DW-2:0], 1'b0};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(DW - 1)) begin
               step_in  = '0;
               state_in = L_DIV;
            end
         end
         L_DIV: begin
            // quotient bits shift into the product register
            rem_in  = q_ge ? DW'(rem_sh - {1'b0, dmag_ff}) : rem_sh[DW-1:0];
            acc_in  = {acc_ff[PW-2:0], q_ge};
            step_in = step_ff + 7'd1;
            if (step_ff == 7'(PW - 1)) begin
               state_in = L_FIN;
            end
         end
         L_FIN: begin
            rsp_in.clamped = q_over;
            if (res > ttbi_pkg::WIDE_LIMIT) begin
               rsp_in.value   = ttbi_pkg::WIDE_LIMIT;
               rsp_in.clamped = 1'b1;
            end else if (res < -ttbi_pkg::WIDE_LIMIT) begin
               rsp_in.value   = -ttbi_pkg::WIDE_LIMIT;
               rsp_in.clamped = 1'b1;
            end else begin
               rsp_in.value = res;
            end
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      a_ff     <= a_in;
      neg_ff   <= neg_in;
      dmag_ff  <= dmag_in;
      emag_ff  <= emag_in;
      dfmag_ff <= dfmag_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      rsp_ff   <= rsp_in;
   end

   assign done = done_ff;
   assign rsp  = rsp_ff;

endmodule

// File: hdl/timing_table_bilinear_interpolator.sv
// Two-dimensional timing table with bilinear interpolation and extrapolation.
// Input channel: a transaction is taken on a clock edge with start high and
// busy low. Operations write a row breakpoint, a column breakpoint or a table
// entry, or run a query at (req_query_row_coordinate,
// req_query_column_coordinate). All values are signed Q16.16.
// Writes complete in the accept cycle and give no result; busy stays low.
// A query raises busy and later returns one result: rsp_valid is high for
// exactly one cycle with rsp_interpolated_value and rsp_saturated. The
// receiver cannot stall, so the result must be taken in that cycle.
// A query runs a row scan, a column scan and the corner reads, then three
// passes through the shared lerp unit (issue, 33 multiply steps, 96 divide
// steps, finish, done); a zero-width segment skips the multiply and divide
// steps. One query is in flight at a time; the next may start in the cycle
// rsp_valid is high. The csr port sets row_count and column_count (reset 1);
// the user is to write them only while idle, which the block does not
// enforce. Reset returns the sequencer to idle; breakpoints and entries
// are undefined until written.
module timing_table_bilinear_interpolator #(
   parameter int MAX_ROWS    = ttbi_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLUMNS = ttbi_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ttbi_pkg::OP_W-1:0]             req_operation,
   input  logic [ttbi_pkg::SLOT_W-1:0]           req_row_slot,
   input  logic [ttbi_pkg::SLOT_W-1:0]           req_column_slot,
   input  logic signed [ttbi_pkg::VALUE_W-1:0]   req_write_value,
   input  logic signed [ttbi_pkg::VALUE_W-1:0]   req_query_row_coordinate,
   input  logic signed [ttbi_pkg::VALUE_W-1:0]   req_query_column_coordinate,
   output logic                                  rsp_valid,
   output logic signed [ttbi_pkg::VALUE_W-1:0]   rsp_interpolated_value,
   output logic                                  rsp_saturated,
   input  logic                                  csr_write_enable,
   input  logic [ttbi_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ttbi_pkg::COUNT_W-1:0]          csr_write_data
);

   localparam int MAX_AXIS = (MAX_ROWS > MAX_COLUMNS) ? MAX_ROWS : MAX_COLUMNS;
   localparam int SW       = $clog2(MAX_AXIS);
   localparam int CW       = $clog2(MAX_AXIS + 1);
   localparam int RAW      = $clog2(MAX_ROWS);
   localparam int CAW      = $clog2(MAX_COLUMNS);
   localparam int TDEPTH   = MAX_ROWS * MAX_COLUMNS;
   localparam int TAW      = $clog2(TDEPTH);
   localparam int VW       = ttbi_pkg::VALUE_W;
   localparam int DW       = ttbi_pkg::DELTA_W;
   localparam int WW       = ttbi_pkg::WIDE_W;
   localparam int NW       = ttbi_pkg::COUNT_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN_R = 4'd1;
   localparam logic [3:0] S_SCAN_C = 4'd2;
   localparam logic [3:0] S_TBL    = 4'd3;
   localparam logic [3:0] S_LERP_T = 4'd4;
   localparam logic [3:0] S_LERP_B = 4'd5;
   localparam logic [3:0] S_LERP_R = 4'd6;

   // control state
   logic [3:0]           state_ff, state_in;
   logic [NW-1:0]        row_count_ff, row_count_in;
   logic [NW-1:0]        column_count_ff, column_count_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic                 dv_ff, dv_in;
   logic [CW-1:0]        didx_ff, didx_in;
   logic                 below_ff, below_in;
   logic                 found_ff, found_in;
   logic [2:0]           tcnt_ff, tcnt_in;
   logic                 tvld_ff, tvld_in;
   logic [1:0]           tidx_ff, tidx_in;
   logic                 issued_ff, issued_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload state
   logic signed [VW-1:0] rv_ff, rv_in, cv_ff, cv_in;
   logic [CW-1:0]        nr_ff, nr_in, nc_ff, nc_in;
   logic signed [VW-1:0] prev_ff, prev_in;
   logic signed [VW-1:0] p0x1_ff, p0x1_in, p0x2_ff, p0x2_in;
   logic [SW-1:0]        mseg_ff, mseg_in;
   logic signed [VW-1:0] mx1_ff, mx1_in, mx2_ff, mx2_in;
   logic [SW-1:0]        r1_ff, r1_in, r2_ff, r2_in, c1_ff, c1_in, c2_ff, c2_in;
   logic signed [DW-1:0] re_ff, re_in, rd_ff, rd_in, ce_ff, ce_in, cd_ff, cd_in;
   logic [VW-1:0]        ent_ff [4];
   logic [VW-1:0]        ent_in [4];
   logic signed [WW-1:0] top_ff, top_in, bottom_ff, bottom_in;
   logic                 sat_ff, sat_in;
   logic signed [VW-1:0] rsp_value_ff, rsp_value_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   // memories and lerp unit
   logic                 accept;
   logic                 row_we, col_we, tbl_we;
   logic [VW-1:0]        row_rd, col_rd, tbl_rd;
   logic [TAW-1:0]       tbl_waddr, tbl_raddr;
   logic [SW-1:0]        tbl_r, tbl_c;
   logic                 lerp_start, lerp_done;
   ttbi_pkg::lerp_req_type lerp_req;
   ttbi_pkg::lerp_rsp_type lerp_rsp;

   // effective counts
   logic [CW-1:0]        nr_eff, nc_eff;

   // breakpoint scan datapath
   logic                 axis_col;
   logic [CW-1:0]        n_cur;
   logic signed [VW-1:0] c_cur, bp_val;
   logic                 scan_match, scan_last, use_stored;
   logic signed [VW-1:0] p0x1_now, p0x2_now;
   logic [SW-1:0]        sel_seg, sel_seg2;
   logic signed [VW-1:0] sel_x1, sel_x2;
   logic signed [DW-1:0] sel_e, sel_d;
   logic signed [WW-1:0] final_val;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // count of 0 acts as 1, above the array size as the size
   always_comb begin
      if (row_count_ff == '0) begin
         nr_eff = CW'(1);
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         nr_eff = CW'(MAX_ROWS);
      end else begin
         nr_eff = CW'(row_count_ff);
      end
      if (column_count_ff == '0) begin
         nc_eff = CW'(1);
      end else if (32'(column_count_ff) > MAX_COLUMNS) begin
         nc_eff = CW'(MAX_COLUMNS);
      end else begin
         nc_eff = CW'(column_count_ff);
      end
   end

   // store writes happen in the accept cycle
   assign row_we    = accept && (req_operation == ttbi_pkg::OP_ROW_BP) &&
                      (32'(req_row_slot) < MAX_ROWS);
   assign col_we    = accept && (req_operation == ttbi_pkg::OP_COLUMN_BP) &&
                      (32'(req_column_slot) < MAX_COLUMNS);
   assign tbl_we    = accept && (req_operation == ttbi_pkg::OP_ENTRY) &&
                      (32'(req_row_slot) < MAX_ROWS) &&
                      (32'(req_column_slot) < MAX_COLUMNS);
   assign tbl_waddr = TAW'(32'(req_row_slot) * MAX_COLUMNS + 32'(req_column_slot));

   // corner order: (r1,c1) (r1,c2) (r2,c1) (r2,c2)
   assign tbl_r     = tcnt_ff[1] ? r2_ff : r1_ff;
   assign tbl_c     = tcnt_ff[0] ? c2_ff : c1_ff;
   assign tbl_raddr = TAW'(32'(tbl_r) * MAX_COLUMNS + 32'(tbl_c));

   ttbi_ram #(.WIDTH(VW), .DEPTH(MAX_ROWS)) u_row_bp (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (RAW'(req_row_slot)),
      .wr_data (req_write_value),
      .rd_addr (issue_ff[RAW-1:0]),
      .rd_data (row_rd)
   );

   ttbi_ram #(.WIDTH(VW), .DEPTH(MAX_COLUMNS)) u_col_bp (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (CAW'(req_column_slot)),
      .wr_data (req_write_value),
      .rd_addr (issue_ff[CAW-1:0]),
      .rd_data (col_rd)
   );

   ttbi_ram #(.WIDTH(VW), .DEPTH(TDEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (req_write_value),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rd)
   );

   ttbi_lerp u_lerp (
      .clock (clock),
      .reset (reset),
      .start (lerp_start),
      .req   (lerp_req),
      .done  (lerp_done),
      .rsp   (lerp_rsp)
   );

   // segment search, one breakpoint per cycle
   assign axis_col   = (state_ff == S_SCAN_C);
   assign n_cur      = axis_col ? nc_ff : nr_ff;
   assign c_cur      = axis_col ? cv_ff : rv_ff;
   assign bp_val     = axis_col ? $signed(col_rd) : $signed(row_rd);
   assign scan_match = (didx_ff != '0) && (prev_ff <= c_cur) && (c_cur <= bp_val);
   assign scan_last  = (didx_ff == CW'(n_cur - CW'(1)));
   assign p0x1_now   = (didx_ff == CW'(1)) ? prev_ff : p0x1_ff;
   assign p0x2_now   = (didx_ff == CW'(1)) ? bp_val  : p0x2_ff;
   assign use_stored = !below_ff && (c_cur <= bp_val) && !scan_match && found_ff;

   always_comb begin
      if (n_cur < CW'(2)) begin
         sel_seg = '0;
         sel_x1  = bp_val;
         sel_x2  = bp_val;
      end else if (below_ff) begin
         sel_seg = '0;
         sel_x1  = p0x1_now;
         sel_x2  = p0x2_now;
      end else if (use_stored) begin
         sel_seg = mseg_ff;
         sel_x1  = mx1_ff;
         sel_x2  = mx2_ff;
      end else begin
         sel_seg = SW'(didx_ff - CW'(1));
         sel_x1  = prev_ff;
         sel_x2  = bp_val;
      end
   end

   assign sel_seg2 = (n_cur < CW'(2)) ? sel_seg : SW'(sel_seg + SW'(1));
   assign sel_e    = {c_cur[VW-1], c_cur} - {sel_x1[VW-1], sel_x1};
   assign sel_d    = {sel_x2[VW-1], sel_x2} - {sel_x1[VW-1], sel_x1};

   // lerp operands per pass
   always_comb begin
      if (state_ff == S_LERP_R) begin
         lerp_req.a = top_ff;
         lerp_req.b = bottom_ff;
         lerp_req.e = re_ff;
         lerp_req.d = rd_ff;
      end else if (state_ff == S_LERP_B) begin
         lerp_req.a = {{(WW-VW){ent_ff[2][VW-1]}}, ent_ff[2]};
         lerp_req.b = {{(WW-VW){ent_ff[3][VW-1]}}, ent_ff[3]};
         lerp_req.e = ce_ff;
         lerp_req.d = cd_ff;
      end else begin
         lerp_req.a = {{(WW-VW){ent_ff[0][VW-1]}}, ent_ff[0]};
         lerp_req.b = {{(WW-VW){ent_ff[1][VW-1]}}, ent_ff[1]};
         lerp_req.e = ce_ff;
         lerp_req.d = cd_ff;
      end
   end

   assign final_val = lerp_rsp.value;

   // sequencer
   always_comb begin
      state_in        = state_ff;
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      issue_in        = issue_ff;
      dv_in           = dv_ff;
      didx_in         = didx_ff;
      below_in        = below_ff;
      found_in        = found_ff;
      tcnt_in         = tcnt_ff;
      tvld_in         = tvld_ff;
      tidx_in         = tidx_ff;
      issued_in       = issued_ff;
      rsp_valid_in    = 1'b0;
      rv_in           = rv_ff;
      cv_in           = cv_ff;
      nr_in           = nr_ff;
      nc_in           = nc_ff;
      prev_in         = prev_ff;
      p0x1_in         = p0x1_ff;
      p0x2_in         = p0x2_ff;
      mseg_in         = mseg_ff;
      mx1_in          = mx1_ff;
      mx2_in          = mx2_ff;
      r1_in           = r1_ff;
      r2_in           = r2_ff;
      c1_in           = c1_ff;
      c2_in           = c2_ff;
      re_in           = re_ff;
      rd_in           = rd_ff;
      ce_in           = ce_ff;
      cd_in           = cd_ff;
      ent_in          = ent_ff;
      top_in          = top_ff;
      bottom_in       = bottom_ff;
      sat_in          = sat_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_sat_in      = rsp_sat_ff;
      lerp_start      = 1'b0;

      // configuration writes
      if (csr_write_enable) begin
         unique case (csr_index)
            ttbi_pkg::CSR_ROW_COUNT:    row_count_in    = csr_write_data;
            ttbi_pkg::CSR_COLUMN_COUNT: column_count_in = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_operation == ttbi_pkg::OP_QUERY)) begin
               rv_in    = req_query_row_coordinate;
               cv_in    = req_query_column_coordinate;
               nr_in    = nr_eff;
               nc_in    = nc_eff;
               issue_in = '0;
               dv_in    = 1'b0;
               found_in = 1'b0;
               below_in = 1'b0;
               sat_in   = 1'b0;
               state_in = S_SCAN_R;
            end
         end
         S_SCAN_R, S_SCAN_C: begin
            // issue reads in order
            if (issue_ff < n_cur) begin
               issue_in = issue_ff + CW'(1);
               dv_in    = 1'b1;
               didx_in  = issue_ff;
            end else begin
               dv_in = 1'b0;
            end
            // examine returned breakpoint
            if (dv_ff) begin
               prev_in = bp_val;
               if (didx_ff == '0) begin
                  below_in = c_cur < bp_val;
               end
               if (didx_ff == CW'(1)) begin
                  p0x1_in = prev_ff;
                  p0x2_in = bp_val;
               end
               if (scan_match) begin
                  found_in = 1'b1;
                  mseg_in  = SW'(didx_ff - CW'(1));
                  mx1_in   = prev_ff;
                  mx2_in   = bp_val;
               end
               if (scan_last) begin
                  issue_in = '0;
                  dv_in    = 1'b0;
                  found_in = 1'b0;
                  below_in = 1'b0;
                  if (axis_col) begin
                     c1_in    = sel_seg;
                     c2_in    = sel_seg2;
                     ce_in    = sel_e;
                     cd_in    = sel_d;
                     tcnt_in  = '0;
                     tvld_in  = 1'b0;
                     state_in = S_TBL;
                  end else begin
                     r1_in    = sel_seg;
                     r2_in    = sel_seg2;
                     re_in    = sel_e;
                     rd_in    = sel_d;
                     state_in = S_SCAN_C;
                  end
               end
            end
         end
         S_TBL: begin
            // fetch the four corners
            if (tcnt_ff < 3'd4) begin
               tcnt_in = tcnt_ff + 3'd1;
               tvld_in = 1'b1;
               tidx_in = tcnt_ff[1:0];
            end else begin
               tvld_in = 1'b0;
            end
            if (tvld_ff) begin
               ent_in[tidx_ff] = tbl_rd;
               if (tidx_ff == 2'd3) begin
                  tvld_in   = 1'b0;
                  issued_in = 1'b0;
                  state_in  = S_LERP_T;
               end
            end
         end
         S_LERP_T, S_LERP_B, S_LERP_R: begin
            lerp_start = !issued_ff;
            if (!issued_ff) begin
               issued_in = 1'b1;
            end
            if (lerp_done) begin
               issued_in = 1'b0;
               sat_in    = sat_ff | lerp_rsp.clamped;
               if (state_ff == S_LERP_T) begin
                  top_in   = lerp_rsp.value;
                  state_in = S_LERP_B;
               end else if (state_ff == S_LERP_B) begin
                  bottom_in = lerp_rsp.value;
                  state_in  = S_LERP_R;
               end else begin
                  // clamp to the 32-bit result range
                  rsp_valid_in = 1'b1;
                  if (final_val > 64'sd2147483647) begin
                     rsp_value_in = 32'sh7FFF_FFFF;
                     rsp_sat_in   = 1'b1;
                  end else if (final_val < -64'sd2147483648) begin
                     rsp_value_in = 32'sh8000_0000;
                     rsp_sat_in   = 1'b1;
                  end else begin
                     rsp_value_in = final_val[VW-1:0];
                     rsp_sat_in   = sat_ff | lerp_rsp.clamped;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         row_count_ff    <= NW'(1);
         column_count_ff <= NW'(1);
         issue_ff        <= '0;
         dv_ff           <= 1'b0;
         didx_ff         <= '0;
         below_ff        <= 1'b0;
         found_ff        <= 1'b0;
         tcnt_ff         <= '0;
         tvld_ff         <= 1'b0;
         tidx_ff         <= '0;
         issued_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         issue_ff        <= issue_in;
         dv_ff           <= dv_in;
         didx_ff         <= didx_in;
         below_ff        <= below_in;
         found_ff        <= found_in;
         tcnt_ff         <= tcnt_in;
         tvld_ff         <= tvld_in;
         tidx_ff         <= tidx_in;
         issued_ff       <= issued_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rv_ff        <= rv_in;
      cv_ff        <= cv_in;
      nr_ff        <= nr_in;
      nc_ff        <= nc_in;
      prev_ff      <= prev_in;
      p0x1_ff      <= p0x1_in;
      p0x2_ff      <= p0x2_in;
      mseg_ff      <= mseg_in;
      mx1_ff       <= mx1_in;
      mx2_ff       <= mx2_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
      c1_ff        <= c1_in;
      c2_ff        <= c2_in;
      re_ff        <= re_in;
      rd_ff        <= rd_in;
      ce_ff        <= ce_in;
      cd_ff        <= cd_in;
      ent_ff       <= ent_in;
      top_ff       <= top_in;
      bottom_ff    <= bottom_in;
      sat_ff       <= sat_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_value_ff;
   assign rsp_saturated          = rsp_sat_ff;

`ifndef ASSERT_OFF
   // a result only follows a query in flight
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a query in flight");

   // the lerp unit only finishes during a lerp pass
   a_lerp_done_state: assert property (@(posedge clock) disable iff (reset)
      lerp_done |-> (state_ff == S_LERP_T || state_ff == S_LERP_B ||
                     state_ff == S_LERP_R))
      else $error("lerp unit finished outside a lerp pass");

   // an accepted query makes the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && req_operation == ttbi_pkg::OP_QUERY) |=> busy)
      else $error("query accepted but block not busy");
`endif

endmodule

// File: tb/tb_timing_table_bilinear_interpolator.sv
`timescale 1ns / 1ps

module tb_timing_table_bilinear_interpolator;

   localparam int NROW = ttbi_pkg::MAX_ROWS_DEFAULT;
   localparam int NCOL = ttbi_pkg::MAX_COLUMNS_DEFAULT;
   localparam int VW = ttbi_pkg::VALUE_W;
   localparam int NW = ttbi_pkg::COUNT_W;
   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic [ttbi_pkg::OP_W-1:0]   op;
      logic [ttbi_pkg::SLOT_W-1:0] rs;
      logic [ttbi_pkg::SLOT_W-1:0] cs;
      logic signed [VW-1:0]        wv;
      logic signed [VW-1:0]        qr;
      logic signed [VW-1:0]        qc;
   } table_op_type;

   typedef struct {
      logic signed [VW-1:0] value;
      logic                 sat;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ttbi_pkg::OP_W-1:0] req_operation = '0;
   logic [ttbi_pkg::SLOT_W-1:0] req_row_slot = '0;
   logic [ttbi_pkg::SLOT_W-1:0] req_column_slot = '0;
   logic signed [VW-1:0] req_write_value = '0;
   logic signed [VW-1:0] req_query_row_coordinate = '0;
   logic signed [VW-1:0] req_query_column_coordinate = '0;
   logic rsp_valid;
   logic signed [VW-1:0] rsp_interpolated_value;
   logic rsp_saturated;
   logic csr_write_enable = 1'b0;
   logic [ttbi_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [NW-1:0] csr_write_data = '0;

   timing_table_bilinear_interpolator DUT (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   table_op_type pending_ops[$];
   lookup_result_type expected_lookups[$];
   int idle_pct = 0;
   int mismatches = 0;
   int queries_done = 0;
   int writes_done = 0;
   int saturated_seen = 0;
   int stall_cycles = 0;
   bit took = 1'b0;

   // predictor state
   logic signed [VW-1:0] row_bp_mirror [NROW];
   logic signed [VW-1:0] col_bp_mirror [NCOL];
   logic signed [VW-1:0] entry_mirror [NROW][NCOL];
   logic [NW-1:0] row_count_mirror = NW'(1);
   logic [NW-1:0] col_count_mirror = NW'(1);

   // stimulus-side copy of the breakpoints, to aim queries
   logic signed [VW-1:0] gen_row_bp [NROW];
   logic signed [VW-1:0] gen_col_bp [NCOL];

   // a + trunc((b-a)*e/d), with the 2^61 clamps
   function automatic ttbi_pkg::lerp_rsp_type blend(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic signed [63:0] e,
                                                    input logic signed [63:0] d);
      ttbi_pkg::lerp_rsp_type r;
      logic signed [63:0] diff;
      logic signed [63:0] res;
      logic [63:0] mdiff, me, md;
      logic [127:0] quo;
      logic neg;
      r.clamped = 1'b0;
      r.value = a;
      if (d == 0) return r;
      diff = b - a;
      neg = (diff < 0) ^ (e < 0) ^ (d < 0);
      mdiff = diff < 0 ? -diff : diff;
      me = e < 0 ? -e : e;
      md = d < 0 ? -d : d;
      quo = ({64'd0, mdiff} * {64'd0, me}) / {64'd0, md};
      if (quo > 128'(ttbi_pkg::WIDE_LIMIT)) begin
         quo = 128'(ttbi_pkg::WIDE_LIMIT);
         r.clamped = 1'b1;
      end
      res = neg ? a - $signed(quo[63:0]) : a + $signed(quo[63:0]);
      if (res > ttbi_pkg::WIDE_LIMIT) begin
         res = ttbi_pkg::WIDE_LIMIT;
         r.clamped = 1'b1;
      end else if (res < -ttbi_pkg::WIDE_LIMIT) begin
         res = -ttbi_pkg::WIDE_LIMIT;
         r.clamped = 1'b1;
      end
      r.value = res;
      return r;
   endfunction

   function automatic int used_count(input logic [NW-1:0] raw, input int top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return int'(raw);
   endfunction

   // segment on one axis: clamp to first/last, else last enclosing segment
   function automatic int axis_segment(input logic signed [VW-1:0] bp [8],
                                       input int n, input logic signed [63:0] c);
      int seg;
      if (n < 2) return 0;
      if (c < bp[0]) return 0;
      seg = n - 2;
      if (c > bp[n-1]) return seg;
      for (int i = 0; i + 1 < n; i++)
         if (c >= bp[i] && c <= bp[i+1]) seg = i;
      return seg;
   endfunction

   function automatic lookup_result_type interpolate(input logic signed [VW-1:0] qr,
                                                     input logic signed [VW-1:0] qc);
      lookup_result_type o;
      ttbi_pkg::lerp_rsp_type top_l, bot_l, fin;
      int nr, nc, r1, r2, c1, c2;
      logic signed [63:0] rv, cv, x1, x2, y1, y2;
      rv = qr;
      cv = qc;
      nr = used_count(row_count_mirror, NROW);
      nc = used_count(col_count_mirror, NCOL);
      r1 = axis_segment(row_bp_mirror, nr, rv);
      r2 = nr < 2 ? r1 : r1 + 1;
      c1 = axis_segment(col_bp_mirror, nc, cv);
      c2 = nc < 2 ? c1 : c1 + 1;
      x1 = col_bp_mirror[c1];
      x2 = col_bp_mirror[c2];
      y1 = row_bp_mirror[r1];
      y2 = row_bp_mirror[r2];
      top_l = blend(entry_mirror[r1][c1], entry_mirror[r1][c2], cv - x1, x2 - x1);
      bot_l = blend(entry_mirror[r2][c1], entry_mirror[r2][c2], cv - x1, x2 - x1);
      fin = blend(top_l.value, bot_l.value, rv - y1, y2 - y1);
      o.sat = top_l.clamped | bot_l.clamped | fin.clamped;
      if (fin.value > 64'sd2147483647) begin
         o.value = 32'sh7FFF_FFFF;
         o.sat = 1'b1;
      end else if (fin.value < -64'sd2147483648) begin
         o.value = 32'sh8000_0000;
         o.sat = 1'b1;
      end else begin
         o.value = fin.value[31:0];
      end
      return o;
   endfunction

   // driver: new transaction at the falling edge once the last one was taken
   always @(negedge clock) begin
      table_op_type t;
      logic go;
      go = start;
      if (!reset && (!start || took)) begin
         go = 1'b0;
         if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct) begin
            t = pending_ops.pop_front();
            req_operation <= t.op;
            req_row_slot <= t.rs;
            req_column_slot <= t.cs;
            req_write_value <= t.wv;
            req_query_row_coordinate <= t.qr;
            req_query_column_coordinate <= t.qc;
            go = 1'b1;
         end
      end
      start <= go;
   end

   // monitor: predict on accept, check each result strobe
   always @(posedge clock) begin
      lookup_result_type exp_r;
      took = 1'b0;
      if (!reset) begin
         stall_cycles++;
         if (csr_write_enable) begin
            if (csr_index == ttbi_pkg::CSR_ROW_COUNT) row_count_mirror = csr_write_data;
            else col_count_mirror = csr_write_data;
         end
         if (rsp_valid) begin
            stall_cycles = 0;
            if (expected_lookups.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result with none expected: value %0d sat %0b",
                           $realtime, rsp_interpolated_value, rsp_saturated);
            end else begin
               exp_r = expected_lookups.pop_front();
               if (rsp_saturated) saturated_seen++;
               if (rsp_interpolated_value !== exp_r.value || rsp_saturated !== exp_r.sat) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch: value %0d sat %0b, expected %0d sat %0b",
                              $realtime, rsp_interpolated_value, rsp_saturated,
                              exp_r.value, exp_r.sat);
               end
            end
         end
         if (start && !busy) begin
            took = 1'b1;
            stall_cycles = 0;
            case (req_operation)
               ttbi_pkg::OP_ROW_BP: row_bp_mirror[req_row_slot] = req_write_value;
               ttbi_pkg::OP_COLUMN_BP: col_bp_mirror[req_column_slot] = req_write_value;
               ttbi_pkg::OP_ENTRY:
                  entry_mirror[req_row_slot][req_column_slot] = req_write_value;
               default: ;
            endcase
            if (req_operation == ttbi_pkg::OP_QUERY) begin
               expected_lookups.insert(expected_lookups.size(),
                                       interpolate(req_query_row_coordinate,
                                                   req_query_column_coordinate));
               queries_done++;
            end else begin
               writes_done++;
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_timing_table_bilinear_interpolator: done, errors");
            $finish;
         end
      end
   end

   task automatic add_op(input logic [ttbi_pkg::OP_W-1:0] op, input int rs, input int cs,
                         input logic signed [31:0] wv, input logic signed [31:0] qr,
                         input logic signed [31:0] qc);
      table_op_type t;
      t.op = op;
      t.rs = ttbi_pkg::SLOT_W'(rs);
      t.cs = ttbi_pkg::SLOT_W'(cs);
      t.wv = wv;
      t.qr = qr;
      t.qc = qc;
      if (op == ttbi_pkg::OP_ROW_BP) gen_row_bp[t.rs] = wv;
      if (op == ttbi_pkg::OP_COLUMN_BP) gen_col_bp[t.cs] = wv;
      pending_ops.insert(pending_ops.size(), t);
   endtask

   // wait for the block to drain, then write both counts
   task automatic set_counts(input int rows, input int cols);
      while (pending_ops.size() > 0 || start || expected_lookups.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= ttbi_pkg::CSR_ROW_COUNT;
      csr_write_data <= NW'(rows);
      @(negedge clock);
      csr_index <= ttbi_pkg::CSR_COLUMN_COUNT;
      csr_write_data <= NW'(cols);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // coordinate near a random breakpoint, or anywhere
   function automatic logic signed [31:0] aim(input bit row_axis);
      logic signed [31:0] base;
      base = row_axis ? gen_row_bp[$urandom_range(NROW-1)] : gen_col_bp[$urandom_range(NCOL-1)];
      if ($urandom_range(9) < 2) return $urandom;
      return base + $signed($urandom_range(196608)) - 32'sd98304;
   endfunction

   task automatic random_ops(input int count, input int step);
      int pick;
      logic signed [31:0] v;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            add_op(ttbi_pkg::OP_QUERY, $urandom_range(7), $urandom_range(7), $urandom,
                   aim(1), aim(0));
         end else if (pick < 75) begin
            v = $urandom_range(9) < 2 ? $signed($urandom)
                                      : $signed($urandom_range(1 << 21)) - 32'sd1048576;
            add_op(ttbi_pkg::OP_ENTRY, $urandom_range(7), $urandom_range(7), v,
                   $urandom, $urandom);
         end else begin
            pick = $urandom_range(7);
            case ($urandom_range(9))
               0: v = $urandom;
               1: v = pick > 0 ? step * (pick - 1) : 0;
               default: v = step * pick + $signed($urandom_range(255)) - 128;
            endcase
            if ($urandom_range(1))
               add_op(ttbi_pkg::OP_ROW_BP, pick, $urandom_range(7), v, $urandom, $urandom);
            else
               add_op(ttbi_pkg::OP_COLUMN_BP, $urandom_range(7), pick, v, $urandom, $urandom);
         end
      end
   endtask

   // stimulus
   initial begin
      int shapes [8][2] = '{'{8, 8}, '{1, 1}, '{2, 3}, '{0, 15}, '{8, 1},
                            '{1, 8}, '{5, 9}, '{3, 2}};
      int idles [4] = '{0, 72, 0, 26};
      int step;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every store slot first so no query reads an unwritten entry
      for (int i = 0; i < NROW; i++)
         add_op(ttbi_pkg::OP_ROW_BP, i, $urandom_range(7), i * 32'sh0001_0000, '0, '0);
      for (int j = 0; j < NCOL; j++)
         add_op(ttbi_pkg::OP_COLUMN_BP, $urandom_range(7), j, j * 32'sh0002_0000, '0, '0);
      for (int i = 0; i < NROW; i++)
         for (int j = 0; j < NCOL; j++)
            add_op(ttbi_pkg::OP_ENTRY, i, j, (i * 8 + j) * 32'sh0000_4000, '0, '0);
      set_counts(8, 8);

      // directed: inside, below, above, full-scale, zero-width, descending
      add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh0001_8000, 32'sh0003_0000);
      add_op(ttbi_pkg::OP_QUERY, 7, 7, '0, 32'sh8000_0000, 32'sh8000_0000);
      add_op(ttbi_pkg::OP_QUERY, 7, 7, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      add_op(ttbi_pkg::OP_ENTRY, 7, 7, 32'sh7FFF_FFFF, '0, '0);
      add_op(ttbi_pkg::OP_ENTRY, 0, 0, 32'sh8000_0000, '0, '0);
      add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh8000_0000, 32'sh8000_0000);
      add_op(ttbi_pkg::OP_ROW_BP, 3, 0, 32'sh0002_0000, '0, '0);
      add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh0002_0000, 32'sh0001_0000);
      add_op(ttbi_pkg::OP_COLUMN_BP, 0, 5, 32'sh0001_0000, '0, '0);
      add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh0004_4000, 32'sh0005_0000);
      add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh0000_4000, 32'sh0000_8000);

      // phases over count settings and sender idling
      for (int p = 0; p < 8; p++) begin
         set_counts(shapes[p][0], shapes[p][1]);
         idle_pct = idles[p % 4];
         step = 32'sh0000_1000 << $urandom_range(6);
         if (p < 2) begin
            add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh8000_0000, 32'sh7FFF_FFFF);
            add_op(ttbi_pkg::OP_QUERY, 0, 0, '0, 32'sh0001_0000, 32'sh0001_0000);
         end
         random_ops(p == 0 ? 100 : 70, step);
      end

      while (pending_ops.size() > 0 || start || expected_lookups.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d writes and %0d lookups (%0d saturated) over 8 count settings",
               writes_done, queries_done, saturated_seen);
      if (mismatches == 0)
         $display("tb_timing_table_bilinear_interpolator: done, clean");
      else
         $display("tb_timing_table_bilinear_interpolator: done, errors");
      $finish;
   end

endmodule
